FILE: hdl/gms_pkg.sv
package gms_pkg;

  localparam int LINE_W   = 64;
  localparam int LEN_W    = 7;
  localparam int MAX_LINE = 64;
  localparam int LEN_RESET = 64;
  localparam int WALL_TIE = 4;

  typedef logic [LINE_W-1:0] line_t;
  typedef logic [LEN_W-1:0]  len_t;

  // Input beat: one map line
  typedef struct packed {
    logic [63:0] line_bits;
    logic        last_line;
  } in_beat_t;

  // Output beat: one smoothed line
  typedef struct packed {
    logic [63:0] smoothed_bits;
    logic        is_last_line;
  } out_beat_t;

  // One smoothing job: three rows, valid-cell mask, last flag
  typedef struct packed {
    line_t above;
    line_t mid;
    line_t below;
    line_t mask;
    logic  last;
  } job_t;

endpackage

FILE: hdl/gms_front.sv
module gms_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  gms_pkg::in_beat_t in_data,
  input  gms_pkg::len_t    line_length,
  output logic             push,
  output gms_pkg::job_t    push_job,
  input  logic             q_full
);
  import gms_pkg::*;

  typedef enum logic [1:0] {HELD_NONE, HELD_ONE, HELD_TWO} held_t;

  held_t held_r, held_nxt;
  logic  pend_vld_r, pend_vld_nxt;
  job_t  pend_job_r, pend_job_nxt;
  line_t older_r, older_nxt;
  line_t middle_r, middle_nxt;
  len_t  len_eff;
  line_t mask;
  line_t cur;
  line_t walls;
  logic  accept;

  // Clamp the line length and build the valid-cell mask
  always_comb begin
    if (line_length == '0) begin
      len_eff = len_t'(1);
    end else if (line_length > len_t'(MAX_LINE)) begin
      len_eff = len_t'(MAX_LINE);
    end else begin
      len_eff = line_length;
    end
    for (int i = 0; i < LINE_W; i++) begin
      mask[i] = (len_t'(i) < len_eff);
    end
  end

  // Drop cells past the line length before a line is buffered
  assign walls    = '1;
  assign cur      = in_data.line_bits & mask;
  assign in_stall = pend_vld_r | q_full;
  assign accept   = in_valid & ~in_stall;

  // Classify each beat into zero, one or two jobs
  always_comb begin
    held_nxt     = held_r;
    pend_vld_nxt = pend_vld_r;
    pend_job_nxt = pend_job_r;
    older_nxt    = older_r;
    middle_nxt   = middle_r;
    push         = 1'b0;
    push_job     = pend_job_r;
    if (pend_vld_r) begin
      // drain the second job of a flush
      if (!q_full) begin
        push         = 1'b1;
        pend_vld_nxt = 1'b0;
      end
    end else if (accept) begin
      if (held_r == HELD_NONE) begin
        if (!in_data.last_line) begin
          middle_nxt = cur;
          held_nxt   = HELD_ONE;
        end else begin
          push     = 1'b1;
          push_job = '{above: walls, mid: cur, below: walls, mask: mask, last: 1'b1};
        end
      end else begin
        push     = 1'b1;
        push_job = '{above: (held_r == HELD_TWO) ? older_r : walls, mid: middle_r,
                     below: cur, mask: mask, last: 1'b0};
        if (in_data.last_line) begin
          pend_job_nxt = '{above: middle_r, mid: cur, below: walls, mask: mask, last: 1'b1};
          pend_vld_nxt = 1'b1;
          held_nxt     = HELD_NONE;
        end else begin
          older_nxt  = middle_r;
          middle_nxt = cur;
          held_nxt   = HELD_TWO;
        end
      end
    end
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r     <= HELD_NONE;
      pend_vld_r <= 1'b0;
    end else begin
      held_r     <= held_nxt;
      pend_vld_r <= pend_vld_nxt;
    end
  end

  // Hold line buffers
  always_ff @(posedge clk) begin
    pend_job_r <= pend_job_nxt;
    older_r    <= older_nxt;
    middle_r   <= middle_nxt;
  end

endmodule

FILE: hdl/gms_queue.sv
module gms_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  gms_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output gms_pkg::job_t head
);
  import gms_pkg::*;

  job_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    cnt_nxt    = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store a job
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

FILE: hdl/gms_back.sv
module gms_back (
  input  logic               clk,
  input  logic               rst_n,
  input  gms_pkg::job_t      head,
  input  logic               empty,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output gms_pkg::out_beat_t out_data
);
  import gms_pkg::*;

  logic              out_valid_r, out_valid_nxt;
  out_beat_t         out_data_r;
  logic [LINE_W+1:0] ext_a, ext_m, ext_b;
  line_t             res;
  logic [3:0]        cnt;

  // Pad each row with walls on both sides and beyond the line length
  assign ext_a = {1'b1, (head.above & head.mask) | ~head.mask, 1'b1};
  assign ext_m = {1'b1, (head.mid   & head.mask) | ~head.mask, 1'b1};
  assign ext_b = {1'b1, (head.below & head.mask) | ~head.mask, 1'b1};

  // Count wall neighbors per cell and apply the majority rule
  always_comb begin
    res = '0;
    cnt = '0;
    for (int i = 0; i < LINE_W; i++) begin
      cnt = 4'(ext_a[i]) + 4'(ext_a[i+1]) + 4'(ext_a[i+2])
          + 4'(ext_m[i]) + 4'(ext_m[i+2])
          + 4'(ext_b[i]) + 4'(ext_b[i+1]) + 4'(ext_b[i+2]);
      if (cnt > 4'(WALL_TIE)) begin
        res[i] = 1'b1;
      end else if (cnt < 4'(WALL_TIE)) begin
        res[i] = 1'b0;
      end else begin
        res[i] = ext_m[i+1];
      end
    end
    res = res & head.mask;
  end

  // Take a job whenever the output register is free or being drained
  assign pop           = ~empty & (~out_valid_r | ~out_stall);
  assign out_valid_nxt = pop | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r <= '{smoothed_bits: res, is_last_line: head.last};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: hdl/binary_grid_majority_smoother_core.sv
// Channel   Ports                           Dir  Beat
// input     in_valid, in_stall, in_data     in   one map line and its last flag
// result    out_valid, out_stall, out_data  out  one smoothed line and its last flag
// config    cfg_valid, cfg_ready, cfg_data  in   line_length, always ready
//
// One line is taken per cycle while in_stall is low; a line marked last with lines
// buffered yields two results and holds in_stall high until the second is issued.
// A queued job passes through the queue and then the output register to the result.
// A two-entry job queue decouples input and result; in_stall rises when it fills.
// Synchronous reset clears the line count, queue and output valid; line_length -> 64.
module binary_grid_majority_smoother_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  gms_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output gms_pkg::out_beat_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  gms_pkg::len_t      cfg_data
);
  import gms_pkg::*;

  len_t line_length_r;
  logic push, q_full, q_empty, pop;
  job_t push_job, head;

  // Hold the line length register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_length_r <= len_t'(LEN_RESET);
    end else if (cfg_valid && cfg_ready) begin
      line_length_r <= cfg_data;
    end
  end

  gms_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .line_length (line_length_r),
    .push        (push),
    .push_job    (push_job),
    .q_full      (q_full)
  );

  gms_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .empty    (q_empty),
    .head     (head)
  );

  gms_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .empty     (q_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: dv/binary_grid_majority_smoother_core_tb.sv
module binary_grid_majority_smoother_core_tb;
  import gms_pkg::*;

  localparam int IDLE_PCT     = 36;
  localparam int QUIET_CYCLES = 12;
  localparam int STALL_LIMIT  = 1000;
  localparam int PHASES       = 12;
  localparam int PHASE_LINES  = 112;

  typedef enum int {
    ROW_RANDOM, ROW_CLEAR, ROW_SOLID, ROW_SPARSE, ROW_DENSE, ROW_CHECKER
  } row_kind_e;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  len_t      cfg_data = '0;

  // stimulus control, written by the sequence with nonblocking assignments
  bit calm = 1'b0;
  bit hold_off = 1'b0;

  in_beat_t  line_backlog[$];
  out_beat_t smoothed_due[$];
  out_beat_t oldest_due;

  // shadow of the smoother: line length and the two buffered lines
  len_t  row_len = len_t'(LEN_RESET);
  line_t upper_row = '0;
  line_t centre_row = '0;
  int    rows_buffered = 0;

  int errors = 0;
  int lines_fed = 0;
  int results_seen = 0;
  int maps_closed = 0;
  int len_writes = 0;
  int idle_count = 0;

  binary_grid_majority_smoother_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int active_len(len_t r);
    if (r == 0) return 1;
    if (r > MAX_LINE) return MAX_LINE;
    return int'(r);
  endfunction

  function automatic line_t cell_mask(int n);
    if (n >= LINE_W) return '1;
    return (line_t'(1) << n) - line_t'(1);
  endfunction

  // cells off the map count as walls
  function automatic int wall_at(line_t row, int col, int n);
    if (col < 0 || col >= n) return 1;
    return int'(row[col]);
  endfunction

  function automatic line_t smooth_row(line_t above, line_t mid, line_t below, int n);
    line_t m;
    line_t res;
    int    walls;
    m = cell_mask(n);
    above = above & m;
    mid = mid & m;
    below = below & m;
    res = '0;
    for (int i = 0; i < n; i++) begin
      walls = wall_at(mid, i - 1, n) + wall_at(mid, i + 1, n);
      for (int dc = -1; dc <= 1; dc++) begin
        walls += wall_at(above, i + dc, n) + wall_at(below, i + dc, n);
      end
      // majority wins, a tie keeps the old cell
      if (walls > WALL_TIE) res[i] = 1'b1;
      else if (walls == WALL_TIE) res[i] = mid[i];
    end
    return res;
  endfunction

  // advance the shadow by one accepted line and queue the lines it releases
  function automatic void predict_line(in_beat_t b);
    int    n;
    line_t cur;
    line_t above;
    n = active_len(row_len);
    cur = b.line_bits & cell_mask(n);
    above = (rows_buffered >= 2) ? upper_row : '1;
    if (rows_buffered == 0) begin
      if (!b.last_line) begin
        centre_row = cur;
        rows_buffered = 1;
        return;
      end
      smoothed_due.push_back(out_beat_t'{smoothed_bits: smooth_row('1, cur, '1, n),
                                         is_last_line: 1'b1});
    end else begin
      smoothed_due.push_back(out_beat_t'{smoothed_bits: smooth_row(above, centre_row, cur, n),
                                         is_last_line: 1'b0});
      if (!b.last_line) begin
        upper_row = centre_row;
        centre_row = cur;
        rows_buffered = 2;
        return;
      end
      smoothed_due.push_back(out_beat_t'{smoothed_bits: smooth_row(centre_row, cur, '1, n),
                                         is_last_line: 1'b1});
    end
    // flush: back to an empty map
    upper_row = '0;
    centre_row = '0;
    rows_buffered = 0;
    maps_closed++;
  endfunction

  function automatic line_t random_row();
    return {$urandom, $urandom};
  endfunction

  function automatic line_t gen_row(row_kind_e k);
    case (k)
      ROW_CLEAR:   return '0;
      ROW_SOLID:   return '1;
      ROW_SPARSE:  return random_row() & random_row();
      ROW_DENSE:   return random_row() | random_row();
      ROW_CHECKER: return $urandom_range(0, 1) ? 64'hAAAA_AAAA_AAAA_AAAA
                                               : 64'h5555_5555_5555_5555;
      default:     return random_row();
    endcase
  endfunction

  task automatic report_mismatch(string what);
    errors++;
    $display("MISMATCH at %0t: %s", $time, what);
  endtask

  task automatic push_line(line_t v, bit last);
    line_backlog.push_back(in_beat_t'{line_bits: v, last_line: last});
  endtask

  // one map of mostly one texture; close marks its final line as last
  task automatic queue_map(int rows, bit close);
    row_kind_e base;
    row_kind_e kind;
    base = row_kind_e'($urandom_range(0, 5));
    for (int r = 0; r < rows; r++) begin
      kind = ($urandom_range(0, 9) < 7) ? base : row_kind_e'($urandom_range(0, 5));
      push_line(gen_row(kind), close && (r == rows - 1));
    end
  endtask

  // drain everything, then let the pipeline settle
  task automatic wait_quiet();
    while (line_backlog.size() != 0 || in_valid || smoothed_due.size() != 0)
      @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_len(len_t v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    row_len = v;
    len_writes++;
  endtask

  // input driver: hold a stalled beat, otherwise offer the next line or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) begin
        predict_line(in_data);
        void'(line_backlog.pop_front());
        lines_fed++;
      end
      if (!hold_off && line_backlog.size() != 0 &&
          (calm || $urandom_range(99) >= IDLE_PCT)) begin
        in_valid <= 1'b1;
        in_data <= line_backlog[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor: compare each beat with the oldest pending line
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (smoothed_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result beat %h", out_data));
        end else begin
          oldest_due = smoothed_due.pop_front();
          if (out_data.smoothed_bits !== oldest_due.smoothed_bits)
            report_mismatch($sformatf("smoothed_bits %h, expected %h",
                                      out_data.smoothed_bits, oldest_due.smoothed_bits));
          if (out_data.is_last_line !== oldest_due.is_last_line)
            report_mismatch($sformatf("is_last_line %b, expected %b",
                                      out_data.is_last_line, oldest_due.is_last_line));
        end
      end
      out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // watchdog: too long without any beat moving ends the run
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        idle_count <= 0;
      end else begin
        idle_count <= idle_count + 1;
        if (idle_count >= STALL_LIMIT) begin
          $display("watchdog: no beat for %0d cycles", idle_count);
          $display("binary_grid_majority_smoother_core verification failed");
          $finish;
        end
      end
    end
  end

  initial begin : sequence_main
    int rows;
    int queued;
    bit close;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: single line maps, short maps, flat and striped rows at full length
    push_line('0, 1'b1);
    push_line('1, 1'b1);
    push_line(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
    push_line('1, 1'b0);
    push_line('0, 1'b1);
    push_line(64'hFFFF_0000_FFFF_0000, 1'b0);
    push_line(random_row(), 1'b0);
    push_line('0, 1'b1);
    wait_quiet();
    // one cell per line, with junk above the length
    write_len(len_t'(1));
    push_line('1, 1'b1);
    push_line('0, 1'b0);
    push_line('1, 1'b0);
    push_line(random_row(), 1'b1);
    wait_quiet();
    // zero length acts as one cell
    write_len(len_t'(0));
    push_line(random_row(), 1'b1);
    push_line('0, 1'b0);
    push_line('0, 1'b1);
    wait_quiet();
    // oversized length acts as the full line
    write_len(len_t'(127));
    push_line(random_row(), 1'b0);
    push_line(random_row(), 1'b1);
    wait_quiet();
    write_len(len_t'(3));
    push_line(random_row(), 1'b0);
    push_line(random_row(), 1'b0);
    push_line(random_row(), 1'b1);
    // length change in the middle of a map
    push_line(random_row(), 1'b0);
    wait_quiet();
    write_len(len_t'(64));
    push_line(random_row(), 1'b0);
    push_line(random_row(), 1'b1);
    wait_quiet();

    // random phases, one length each, maps of random texture
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: write_len(len_t'(LEN_RESET));
        1: write_len(len_t'(1));
        2: write_len(len_t'(0));
        3: write_len(len_t'(127));
        4: write_len(len_t'(2));
        5: write_len(len_t'(63));
        default: begin
          if ($urandom_range(0, 3) == 0) write_len(len_t'($urandom_range(0, 127)));
          else write_len(len_t'($urandom_range(1, 64)));
        end
      endcase
      calm <= (p == 6);
      queued = 0;
      while (queued < PHASE_LINES) begin
        rows = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 5);
        close = ((p == PHASES - 1) && (queued + rows >= PHASE_LINES)) ||
                ($urandom_range(0, 7) != 0);
        queue_map(rows, close);
        queued += rows;
      end
      // hold the sender until every pending line has come out
      if (p == 8) begin
        while (line_backlog.size() > PHASE_LINES / 2) @(posedge clk);
        hold_off <= 1'b1;
        do @(posedge clk); while (in_valid || smoothed_due.size() != 0);
        repeat (8) @(posedge clk);
        hold_off <= 1'b0;
      end
      wait_quiet();
    end

    if (smoothed_due.size() != 0)
      report_mismatch($sformatf("%0d smoothed lines never arrived", smoothed_due.size()));
    $display("run: %0d lines fed, %0d maps flushed, %0d smoothed lines checked",
             lines_fed, maps_closed, results_seen);
    $display("run: %0d line length writes incl. zero, one, full and oversized", len_writes);
    if (errors == 0) begin
      $display("binary_grid_majority_smoother_core verification clean");
    end else begin
      $display("binary_grid_majority_smoother_core verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/gms_pkg.sv
hdl/gms_front.sv
hdl/gms_queue.sv
hdl/gms_back.sv
hdl/binary_grid_majority_smoother_core.sv
dv/binary_grid_majority_smoother_core_tb.sv
